// ===== hdl/tcet_pkg.sv =====
// ----------------------------------------------------------------------------
// tcet_pkg
// Shared types and constants of the touch contact event tracker: sample and
// result payloads, configuration set, per-slot control and result records.
// ----------------------------------------------------------------------------
package tcet_pkg;

    // coordinate and count widths
    localparam int unsigned COORD_W = 16;
    localparam int unsigned COUNT_W = 8;

    // configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_INVERT_BEFORE_SWAP = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SWAP_AXES          = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_X           = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_Y           = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_EXTENT           = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_EXTENT           = 3'd5;

    // extent reset values
    localparam logic [COORD_W-1:0] X_EXTENT_RST = 16'd800;
    localparam logic [COORD_W-1:0] Y_EXTENT_RST = 16'd480;

    // contact counts that matter to the slots
    localparam logic [COUNT_W-1:0] COUNT_NONE = 8'd0;
    localparam logic [COUNT_W-1:0] COUNT_TWO  = 8'd2;

    // slot event codes
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_MOVE    = 2'd2,
        EV_RELEASE = 2'd3
    } t_event;

    // one raw touch sample
    typedef struct packed {
        logic               int_asserted;
        logic [COUNT_W-1:0] contact_count;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
    } t_sample;

    // one result item
    typedef struct packed {
        t_event             first_event;
        logic [COORD_W-1:0] first_x_out;
        logic [COORD_W-1:0] first_y_out;
        logic               first_x_changed;
        logic               first_y_changed;
        t_event             second_event;
        logic [COORD_W-1:0] second_x_out;
        logic [COORD_W-1:0] second_y_out;
        logic               second_x_changed;
        logic               second_y_changed;
        logic               frame_sync;
    } t_result;

    // configuration set seen by the lanes
    typedef struct packed {
        logic               invert_before_swap;
        logic               swap_axes;
        logic               invert_x;
        logic               invert_y;
        logic [COORD_W-1:0] x_extent;
        logic [COORD_W-1:0] y_extent;
    } t_cfg;

    // per-slot activity, derived from current and previous counts
    typedef struct packed {
        logic active;
        logic was_active;
        logic fresh;
    } t_slot_ctl;

    // per-slot findings
    typedef struct packed {
        t_event             event_code;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               x_changed;
        logic               y_changed;
    } t_slot_res;

endpackage

// ===== hdl/tcet_cfg.sv =====
// ----------------------------------------------------------------------------
// tcet_cfg
// Configuration registers behind an APB-style port. Writes land on the
// access cycle; reads return the stored value, zero outside the map.
// ----------------------------------------------------------------------------
module tcet_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcet_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tcet_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tcet_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output tcet_pkg::t_cfg                      o_cfg
);
    import tcet_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert_before_swap <= 1'b0;
            r_cfg.swap_axes          <= 1'b0;
            r_cfg.invert_x           <= 1'b0;
            r_cfg.invert_y           <= 1'b0;
            r_cfg.x_extent           <= X_EXTENT_RST;
            r_cfg.y_extent           <= Y_EXTENT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_INVERT_BEFORE_SWAP: r_cfg.invert_before_swap <= pwdata[0];
                REG_SWAP_AXES:          r_cfg.swap_axes          <= pwdata[0];
                REG_INVERT_X:           r_cfg.invert_x           <= pwdata[0];
                REG_INVERT_Y:           r_cfg.invert_y           <= pwdata[0];
                REG_X_EXTENT:           r_cfg.x_extent           <= pwdata[COORD_W-1:0];
                REG_Y_EXTENT:           r_cfg.y_extent           <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_INVERT_BEFORE_SWAP: prdata[0] = r_cfg.invert_before_swap;
            REG_SWAP_AXES:          prdata[0] = r_cfg.swap_axes;
            REG_INVERT_X:           prdata[0] = r_cfg.invert_x;
            REG_INVERT_Y:           prdata[0] = r_cfg.invert_y;
            REG_X_EXTENT:           prdata[COORD_W-1:0] = r_cfg.x_extent;
            REG_Y_EXTENT:           prdata[COORD_W-1:0] = r_cfg.y_extent;
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/tcet_lane.sv =====
// ----------------------------------------------------------------------------
// tcet_lane
// One contact slot: orients the raw coordinates (swap and inversion in the
// configured order) and judges press, move or release against the kept pair.
// ----------------------------------------------------------------------------
module tcet_lane (
    input  tcet_pkg::t_cfg                      i_cfg,
    input  tcet_pkg::t_slot_ctl                 i_ctl,
    input  logic [tcet_pkg::COORD_W-1:0]        i_raw_x,
    input  logic [tcet_pkg::COORD_W-1:0]        i_raw_y,
    input  logic [tcet_pkg::COORD_W-1:0]        i_prev_x,
    input  logic [tcet_pkg::COORD_W-1:0]        i_prev_y,
    output tcet_pkg::t_slot_res                 o_res
);
    import tcet_pkg::*;

    logic [COORD_W-1:0] pre_x, pre_y;
    logic [COORD_W-1:0] sw_x, sw_y;
    logic [COORD_W-1:0] fin_x, fin_y;
    logic               x_diff, y_diff;

    // inversion ahead of the swap
    always_comb begin
        pre_x = i_raw_x;
        pre_y = i_raw_y;
        if (i_cfg.invert_before_swap && i_cfg.invert_x) begin
            pre_x = i_cfg.x_extent - i_raw_x;
        end
        if (i_cfg.invert_before_swap && i_cfg.invert_y) begin
            pre_y = i_cfg.y_extent - i_raw_y;
        end
    end

    // axis swap
    assign sw_x = i_cfg.swap_axes ? pre_y : pre_x;
    assign sw_y = i_cfg.swap_axes ? pre_x : pre_y;

    // inversion after the swap
    always_comb begin
        fin_x = sw_x;
        fin_y = sw_y;
        if (!i_cfg.invert_before_swap && i_cfg.invert_x) begin
            fin_x = i_cfg.x_extent - sw_x;
        end
        if (!i_cfg.invert_before_swap && i_cfg.invert_y) begin
            fin_y = i_cfg.y_extent - sw_y;
        end
    end

    assign x_diff = (fin_x != i_prev_x);
    assign y_diff = (fin_y != i_prev_y);

    // event judgment
    always_comb begin
        o_res.event_code = EV_NONE;
        o_res.x          = fin_x;
        o_res.y          = fin_y;
        o_res.x_changed  = 1'b0;
        o_res.y_changed  = 1'b0;
        priority if (i_ctl.active && i_ctl.fresh) begin
            o_res.event_code = EV_PRESS;
            o_res.x_changed  = 1'b1;
            o_res.y_changed  = 1'b1;
        end else if (i_ctl.active && (x_diff || y_diff)) begin
            o_res.event_code = EV_MOVE;
            o_res.x_changed  = x_diff;
            o_res.y_changed  = y_diff;
        end else if (!i_ctl.active && i_ctl.was_active) begin
            o_res.event_code = EV_RELEASE;
        end else begin
            o_res.event_code = EV_NONE;
        end
    end

endmodule

// ===== hdl/touch_contact_event_tracker.sv =====
// ----------------------------------------------------------------------------
// touch_contact_event_tracker
// Turns two-contact touch samples into press, move and release events.
// ----------------------------------------------------------------------------
// For each accepted sample, two slot lanes orient their contact and compare
// it with the kept coordinates, and the merge stage sets frame_sync and loads
// the result into the output register. A sample is dropped without a result
// when the interrupt is low and no contact was active. A new sample is taken
// every cycle as long as the output register is empty or its result is taken
// in that same cycle; the stall on the input follows the output register alone.
// The user must write configuration through the APB port only while no sample
// is in flight; the block itself does not enforce this.
module touch_contact_event_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tcet_pkg::t_sample                   i_in_data,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tcet_pkg::t_result                   o_out_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcet_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tcet_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tcet_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tcet_pkg::*;

    t_cfg               cfg;
    t_slot_ctl          ctl_first, ctl_second;
    t_slot_res          res_first, res_second;
    t_result            n_out_data;
    t_result            r_out_data;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_prev_first_x, r_prev_first_y;
    logic [COORD_W-1:0] r_prev_second_x, r_prev_second_y;
    logic [COUNT_W-1:0] r_prev_count;
    logic               in_xfer;
    logic               process;
    logic               prev_active, prev_two;

    // configuration registers
    tcet_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // slot activity from current and kept counts
    assign prev_active = (r_prev_count != COUNT_NONE);
    assign prev_two    = (r_prev_count == COUNT_TWO);

    assign ctl_first.active      = (i_in_data.contact_count != COUNT_NONE);
    assign ctl_first.was_active  = prev_active;
    assign ctl_first.fresh       = !prev_active;
    assign ctl_second.active     = (i_in_data.contact_count == COUNT_TWO);
    assign ctl_second.was_active = prev_two;
    assign ctl_second.fresh      = !prev_active || (r_prev_count == 8'd1);

    // slot lanes
    tcet_lane u_lane_first (
        .i_cfg    (cfg),
        .i_ctl    (ctl_first),
        .i_raw_x  (i_in_data.first_x),
        .i_raw_y  (i_in_data.first_y),
        .i_prev_x (r_prev_first_x),
        .i_prev_y (r_prev_first_y),
        .o_res    (res_first)
    );

    tcet_lane u_lane_second (
        .i_cfg    (cfg),
        .i_ctl    (ctl_second),
        .i_raw_x  (i_in_data.second_x),
        .i_raw_y  (i_in_data.second_y),
        .i_prev_x (r_prev_second_x),
        .i_prev_y (r_prev_second_y),
        .o_res    (res_second)
    );

    // merge lane findings into one result
    always_comb begin
        n_out_data.first_event      = res_first.event_code;
        n_out_data.first_x_out      = res_first.x;
        n_out_data.first_y_out      = res_first.y;
        n_out_data.first_x_changed  = res_first.x_changed;
        n_out_data.first_y_changed  = res_first.y_changed;
        n_out_data.second_event     = res_second.event_code;
        n_out_data.second_x_out     = res_second.x;
        n_out_data.second_y_out     = res_second.y;
        n_out_data.second_x_changed = res_second.x_changed;
        n_out_data.second_y_changed = res_second.y_changed;
        n_out_data.frame_sync       = (res_first.event_code != EV_NONE) ||
                                      (res_second.event_code != EV_NONE);
    end

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign process    = in_xfer && (i_in_data.int_asserted || prev_active);

    // kept contact state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_first_x  <= '0;
            r_prev_first_y  <= '0;
            r_prev_second_x <= '0;
            r_prev_second_y <= '0;
            r_prev_count    <= '0;
        end else if (process) begin
            r_prev_first_x  <= res_first.x;
            r_prev_first_y  <= res_first.y;
            r_prev_second_x <= res_second.x;
            r_prev_second_y <= res_second.y;
            r_prev_count    <= i_in_data.contact_count;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= process;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
